// ===== rtl/sfq_pkg.sv =====
`default_nettype none

package sfq_pkg;

   // Fixed field widths of the command and response transfers.
   localparam int SIG_W      = 4;
   localparam int CMD_W      = 3;
   localparam int SIG_OUT_W  = 5;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   // Default sizes handed to the top level parameters.
   localparam int DEPTH_DEF       = 32;
   localparam int NUM_SIGNALS_DEF = 16;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_ADV    = 3'd5;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd6;

   // One response as the sequencer hands it to the output stage.
   typedef struct packed {
      logic                 push_dropped;
      logic                 cursor_at_end;
      logic                 queue_empty;
      logic [SIG_OUT_W-1:0] signal_out;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/sfq_ram.sv =====
`default_nettype none

module sfq_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/sfq_ctrl.sv =====
`default_nettype none

module sfq_ctrl
   import sfq_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int NUM_SIGNALS = NUM_SIGNALS_DEF,
   parameter int AW          = $clog2(DEPTH),
   parameter int CW          = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // Command side.
   input  wire logic             cmd_valid,
   output logic                  cmd_ready,
   input  wire logic [CMD_W-1:0] cmd,
   input  wire logic [SIG_W-1:0] sig,
   // Response side.
   output logic                  rsp_valid,
   input  wire logic             rsp_take,
   output rsp_type               rsp,
   // Entry memory.
   output logic                  ram_we,
   output logic      [AW-1:0]    ram_waddr,
   output logic      [SIG_W-1:0] ram_wdata,
   output logic      [AW-1:0]    ram_raddr,
   input  wire logic [SIG_W-1:0] ram_rdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_SH_RD = 3'd2;
   localparam logic [2:0] ST_SH_WR = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic [SIG_OUT_W-1:0] NONE_CODE = SIG_OUT_W'(NUM_SIGNALS);
   localparam logic [CW-1:0]        FULL_CNT  = CW'(DEPTH);

   logic [2:0]           state_ff, state_in;
   logic [CW-1:0]        occ_ff, occ_in;
   logic [CW-1:0]        cur_ff, cur_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [SIG_OUT_W-1:0] res_ff, res_in;
   logic                 drop_ff, drop_in;
   logic [CW-1:0]        nxt;
   logic                 cur_live;

   // The shared index unit: the position just behind the one being closed up.
   assign nxt      = CW'(idx_ff) + CW'(1);
   assign cur_live = (cur_ff < occ_ff);

   always_comb begin
      state_in  = state_ff;
      occ_in    = occ_ff;
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      cmd_in    = cmd_ff;
      res_in    = res_ff;
      drop_in   = drop_ff;
      ram_we    = 1'b0;
      ram_waddr = occ_ff[AW-1:0];
      ram_wdata = sig;
      ram_raddr = nxt[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_in   = cmd;
               res_in   = NONE_CODE;
               drop_in  = 1'b0;
               state_in = ST_DONE;
               case (cmd)
                  CMD_PUSH: begin
                     if (occ_ff < FULL_CNT) begin
                        ram_we = 1'b1;
                        occ_in = occ_ff + CW'(1);
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  CMD_POP, CMD_PEEK: begin
                     if (occ_ff != '0) begin
                        ram_raddr = '0;
                        state_in  = ST_READ;
                     end
                  end
                  CMD_HEAD: begin
                     cur_in = '0;
                  end
                  CMD_READ: begin
                     if (cur_live) begin
                        ram_raddr = cur_ff[AW-1:0];
                        state_in  = ST_READ;
                     end
                  end
                  CMD_ADV: begin
                     if (cur_live) begin
                        cur_in = cur_ff + CW'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     if (cur_live) begin
                        idx_in   = cur_ff[AW-1:0];
                        state_in = ST_SH_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            res_in = SIG_OUT_W'(ram_rdata);
            if (cmd_ff == CMD_POP) begin
               idx_in   = '0;
               state_in = ST_SH_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SH_RD: begin
            // Fetch the entry behind the gap, or stop at the tail.
            if (nxt < occ_ff) begin
               state_in = ST_SH_WR;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_SH_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = ram_rdata;
            idx_in    = nxt[AW-1:0];
            state_in  = ST_SH_RD;
         end
         ST_FIN: begin
            occ_in = occ_ff - CW'(1);
            if (cmd_ff == CMD_POP && cur_ff != '0) begin
               cur_in = cur_ff - CW'(1);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff   <= '0;
         cur_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         cur_ff   <= cur_in;
      end
      idx_ff  <= idx_in;
      cmd_ff  <= cmd_in;
      res_ff  <= res_in;
      drop_ff <= drop_in;
   end

   assign cmd_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = (state_ff == ST_DONE);
   assign rsp.signal_out    = res_ff;
   assign rsp.queue_empty   = (occ_ff == '0);
   assign rsp.cursor_at_end = !cur_live;
   assign rsp.push_dropped  = drop_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_CNT)
      else $error("occupancy exceeds depth");

   a_cur_bound: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= occ_ff)
      else $error("cursor beyond occupancy");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == $past(occ_ff)) || (occ_ff == $past(occ_ff) + CW'(1)) ||
      (occ_ff == $past(occ_ff) - CW'(1)))
      else $error("occupancy moved by more than one");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SH_WR) |-> (nxt < occ_ff))
      else $error("close-up write past the tail");

   a_occ_only_idle_or_fin: assert property (@(posedge clock) disable iff (reset)
      (occ_ff != $past(occ_ff)) |-> ($past(state_ff) == ST_IDLE ||
                                     $past(state_ff) == ST_FIN))
      else $error("occupancy changed outside accept or finish");

endmodule

`default_nettype wire

// ===== rtl/signal_fifo_with_cursor_removal_top.sv =====
`default_nettype none

// Channel   Direction  Width  Contents (lowest bit first)
// req_*     in         8      command[2:0], signal_id[6:3], zero[7]
// rsp_*     out        8      signal_out[4:0], queue_empty[5], cursor_at_end[6],
//                             push_dropped[7]
//
// One command is in work at a time; req_tready is high only while the sequencer
// is idle. Push, cursor to head, advance and any command that finds nothing to
// do go straight to the response; peek and read first read the entry memory.
// Remove and pop (after pop's head read) close the gap with one entry memory
// read and one write per moved entry, then lower the occupancy. The response
// is loaded into the output register at the edge where the sequencer returns
// to idle.
// Reset is synchronous and active high; it empties the queue and homes the
// cursor. The response register lets the next command start while a finished
// response still waits for rsp_tready.
module signal_fifo_with_cursor_removal_top
   import sfq_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEF,
   parameter int NUM_SIGNALS = NUM_SIGNALS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // command[2:0], signal_id[6:3], zero pad[7]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // signal_out[4:0], queue_empty[5], cursor_at_end[6], push_dropped[7]
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(DEPTH);

   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [AW-1:0]    ram_raddr;
   logic [SIG_W-1:0] ram_wdata;
   logic [SIG_W-1:0] ram_rdata;

   logic    seq_rsp_valid;
   logic    out_free;
   rsp_type seq_rsp;

   // Output register: valid flag and the held response transfer.
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;

   sfq_ram #(
      .WIDTH (SIG_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sfq_ctrl #(
      .DEPTH       (DEPTH),
      .NUM_SIGNALS (NUM_SIGNALS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid),
      .cmd_ready (req_tready),
      .cmd       (req_tdata[CMD_W-1:0]),
      .sig       (req_tdata[CMD_W +: SIG_W]),
      .rsp_valid (seq_rsp_valid),
      .rsp_take  (out_free),
      .rsp       (seq_rsp),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   // The register can take a new response when it is empty or being drained.
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_free) begin
         out_valid_in = seq_rsp_valid;
         if (seq_rsp_valid) begin
            out_data_in = seq_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_data_ff);

endmodule

`default_nettype wire

// ===== sim/sfq_stream_checker.sv =====
`timescale 1ns / 1ps

// Watches both stream channels of the signal queue, keeps its own copy of the
// queue and cursor, and compares every response transfer with the expectation
// that the matching command produced.
module sfq_stream_checker
   import sfq_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  end_check,
   output int                         fail_count,
   output int                         pending_count
);

   logic [SIG_W-1:0] held_sig[$];
   int               cursor_pos    = 0;
   rsp_type          pending_rsp[$];
   int               errors        = 0;
   logic             leftover_done = 1'b0;

   // Applies one command to the shadow queue and returns the response it earns.
   function automatic rsp_type apply_command(input logic [CMD_W-1:0] cmd,
                                             input logic [SIG_W-1:0] sig);
      rsp_type              r;
      logic [SIG_OUT_W-1:0] val;
      logic                 dropped;
      val     = SIG_OUT_W'(NUM_SIGNALS_DEF);
      dropped = 1'b0;
      case (cmd)
         CMD_PUSH: begin
            if (held_sig.size() < DEPTH_DEF) held_sig.push_back(sig);
            else dropped = 1'b1;
         end
         CMD_POP: begin
            if (held_sig.size() > 0) begin
               val = SIG_OUT_W'(held_sig.pop_front());
               if (cursor_pos > 0) cursor_pos--;
            end
         end
         CMD_PEEK: begin
            if (held_sig.size() > 0) val = SIG_OUT_W'(held_sig[0]);
         end
         CMD_HEAD: cursor_pos = 0;
         CMD_READ: begin
            if (cursor_pos < held_sig.size()) val = SIG_OUT_W'(held_sig[cursor_pos]);
         end
         CMD_ADV: begin
            if (cursor_pos < held_sig.size()) cursor_pos++;
         end
         CMD_REMOVE: begin
            if (cursor_pos < held_sig.size()) held_sig.delete(cursor_pos);
         end
         default: ;
      endcase
      r.signal_out    = val;
      r.queue_empty   = (held_sig.size() == 0);
      r.cursor_at_end = (cursor_pos >= held_sig.size());
      r.push_dropped  = dropped;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         held_sig.delete();
         pending_rsp.delete();
         cursor_pos = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata);
            if (pending_rsp.size() == 0) begin
               $error("unexpected response transfer: tdata 0x%02h", rsp_tdata);
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               if (got.signal_out !== want.signal_out) begin
                  $error("signal_out: expected %0d, actual %0d",
                         want.signal_out, got.signal_out);
                  errors++;
               end
               if (got.queue_empty !== want.queue_empty) begin
                  $error("queue_empty: expected %0d, actual %0d",
                         want.queue_empty, got.queue_empty);
                  errors++;
               end
               if (got.cursor_at_end !== want.cursor_at_end) begin
                  $error("cursor_at_end: expected %0d, actual %0d",
                         want.cursor_at_end, got.cursor_at_end);
                  errors++;
               end
               if (got.push_dropped !== want.push_dropped) begin
                  $error("push_dropped: expected %0d, actual %0d",
                         want.push_dropped, got.push_dropped);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_rsp.push_back(apply_command(req_tdata[CMD_W-1:0],
                                                req_tdata[CMD_W +: SIG_W]));
         if (end_check && !leftover_done) begin
            leftover_done = 1'b1;
            if (pending_rsp.size() != 0) begin
               $error("%0d responses never arrived", pending_rsp.size());
               errors += pending_rsp.size();
            end
         end
      end
      pending_count <= pending_rsp.size();
      fail_count    <= errors;
   end

endmodule

// ===== sim/tb_signal_fifo_with_cursor_removal_top.sv =====
`timescale 1ns / 1ps

// Top of the signal queue bench. This module only makes traffic: it drives
// commands into the request channel, throttles the response channel, and
// prints the verdict. All prediction and comparison live in the checker that
// sits beside the block and watches both channels.
module tb_signal_fifo_with_cursor_removal_top;
   import sfq_pkg::*;

   // Code 7 is not a command; the block must treat it as a no-op.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

   // Length of the one long receiver hold-off, in cycles. It is far longer
   // than any single command, so the block fills its response register and
   // then has to drop req_tready.
   localparam int LONG_HOLD = 300;

   // A remove near the head of a full queue walks nearly the whole queue, so this
   // many quiet cycles at the end are enough to catch a stray response.
   localparam int DRAIN_CYCLES = 100;

   localparam int SIG_MAX = (1 << SIG_W) - 1;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  end_check  = 1'b0;
   int                    fail_count;
   int                    pending_count;

   // Traffic shaping knobs. The idle and stall figures are percentages per
   // cycle. The hold-off is requested by bumping hold_req; the receiver
   // process notices the change and counts the stretch down itself.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_req       = 0;
   int hold_seen      = 0;
   int hold_left      = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   signal_fifo_with_cursor_removal_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sfq_stream_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .end_check     (end_check),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Response side. Outside a hold-off, rsp_tready is dropped at random with
   // the current stall percentage; a stall percentage of zero keeps it high.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offers one command and returns at the clock edge where it transfers.
   // An idle gap, when one is drawn, lowers tvalid in the step of the previous
   // transfer and raises it again only after at least one whole cycle, so
   // tvalid never sees two assignments in one step.
   task automatic issue_command(input logic [CMD_W-1:0] cmd,
                                input logic [SIG_W-1:0] sig);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({sig, cmd});
      do @(posedge clock); while (!req_tready);
   endtask

   // One random command. Pushes come at the given rate; the rest lean toward
   // cursor moves and reads so the cursor wanders away from the head.
   task automatic issue_random(input int push_pct);
      logic [CMD_W-1:0] cmd;
      int               pick;
      if ($urandom_range(99) < push_pct) begin
         cmd = CMD_PUSH;
      end else begin
         pick = $urandom_range(12);
         case (pick)
            0, 1:    cmd = CMD_POP;
            2:       cmd = CMD_PEEK;
            3:       cmd = CMD_HEAD;
            4, 5:    cmd = CMD_READ;
            6, 7, 8: cmd = CMD_ADV;
            9, 10:   cmd = CMD_REMOVE;
            11:      cmd = CMD_READ;
            default: cmd = CMD_UNUSED;
         endcase
      end
      issue_command(cmd, SIG_W'($urandom_range(SIG_MAX)));
   endtask

   initial begin
      int push_pct;
      int run_len;
      int pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, no idling on either side. Every command first meets an
      // empty queue, then a short queue is built and walked: the cursor keeps
      // its entry across a head pop, a removal closes the gap, the cursor runs
      // past the end, and a push lands under a cursor that stood at the end.
      issue_command(CMD_PEEK, '0);
      issue_command(CMD_POP, '0);
      issue_command(CMD_READ, '0);
      issue_command(CMD_ADV, '0);
      issue_command(CMD_REMOVE, '0);
      issue_command(CMD_UNUSED, 4'hF);
      issue_command(CMD_HEAD, '0);
      issue_command(CMD_PUSH, 4'h0);
      issue_command(CMD_PUSH, 4'hF);
      issue_command(CMD_PUSH, 4'h5);
      issue_command(CMD_READ, '0);
      issue_command(CMD_ADV, '0);
      issue_command(CMD_READ, '0);
      issue_command(CMD_PEEK, '0);
      issue_command(CMD_POP, '0);
      issue_command(CMD_READ, '0);
      issue_command(CMD_REMOVE, '0);
      issue_command(CMD_READ, '0);
      issue_command(CMD_ADV, '0);
      issue_command(CMD_ADV, '0);
      issue_command(CMD_READ, '0);
      issue_command(CMD_REMOVE, '0);
      issue_command(CMD_PUSH, 4'h9);
      issue_command(CMD_READ, '0);
      issue_command(CMD_POP, '0);

      // Fill the queue past capacity so the last pushes are refused.
      repeat (DEPTH_DEF + 2) issue_command(CMD_PUSH, SIG_W'($urandom_range(SIG_MAX)));

      // Random part in four traffic phases. Each segment opens with a scan:
      // cursor to head, then a run that mostly advances, with reads and
      // removals mixed in, so deep cursor positions get exercised. Then come
      // random commands with a push rate drawn per segment, which lets the
      // queue swing between nearly empty and full.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               // The long hold-off falls in this phase, while the sender keeps
               // offering commands back to back.
               hold_req++;
            end
            1: begin
               send_idle_pct  = 50;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 50;
            end
            default: begin
               send_idle_pct  = 13;
               recv_stall_pct = 13;
            end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            case ($urandom_range(2))
               0:       push_pct = 70;
               1:       push_pct = 45;
               default: push_pct = 25;
            endcase
            issue_command(CMD_HEAD, '0);
            run_len = $urandom_range(20, 6);
            repeat (run_len) begin
               pick = $urandom_range(9);
               if (pick < 6)      issue_command(CMD_ADV, '0);
               else if (pick < 8) issue_command(CMD_READ, '0);
               else               issue_command(CMD_REMOVE, '0);
            end
            repeat (20) issue_random(push_pct);
         end
      end
      req_tvalid <= 1'b0;

      // Wait for every expected response, then give the block time to show
      // any response it should not produce.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      end_check <= 1'b1;
      repeat (2) @(posedge clock);

      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of this stimulus.
   initial begin
      #1_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sfq_pkg.sv
rtl/sfq_ram.sv
rtl/sfq_ctrl.sv
rtl/signal_fifo_with_cursor_removal_top.sv
sim/sfq_stream_checker.sv
sim/tb_signal_fifo_with_cursor_removal_top.sv
